// ----- rtl/tcw_pkg.sv -----
`timescale 1ns / 1ps

package tcw_pkg;

    // field widths of the item ports
    localparam int C_COL_W  = 7;
    localparam int C_ROW_W  = 5;
    localparam int C_BYTE_W = 8;
    localparam int C_OP_W   = 2;
    localparam int C_CELL_W = 16;

    // configuration register indexes
    localparam int C_CFG_IDX_W = 1;
    localparam logic [C_CFG_IDX_W-1:0] REG_DEFAULT_ATTR = 1'b0;
    localparam logic [C_CFG_IDX_W-1:0] REG_ERROR_ATTR   = 1'b1;

    localparam logic [C_BYTE_W-1:0] DEFAULT_ATTR_RST = 8'd15;
    localparam logic [C_BYTE_W-1:0] ERROR_ATTR_RST   = 8'd244;

    typedef logic [C_OP_W-1:0] t_op;
    localparam t_op OP_PUT   = 2'd0;
    localparam t_op OP_BKSP  = 2'd1;
    localparam t_op OP_CLEAR = 2'd2;
    localparam t_op OP_READ  = 2'd3;

    localparam logic [C_BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [C_BYTE_W-1:0] CH_BLANK   = 8'h08;
    localparam logic [C_BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [C_BYTE_W-1:0] CH_ERROR   = 8'h45;

    typedef struct packed {
        logic [C_BYTE_W-1:0] attr;
        logic [C_BYTE_W-1:0] ch;
    } t_cell;

endpackage

// ----- rtl/text_console_writer.sv -----
`timescale 1ns / 1ps
// Text console writer: a character/attribute cell store with a cursor.
// Input channel (i_in_valid / o_in_ready) carries one command: put character,
// backspace, clear screen or read cell. Output channel (o_out_valid /
// i_out_ready) returns one result per command: cursor after the command,
// position error flag and, for a read, the cell contents.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes the
// default attribute (index 0) and the error attribute (index 1); write it
// only while no command is in flight.
// A plain command passes through the exec and done states before the next
// input transfer; its result is loaded into the output register in done.
// The store is one memory with one write and one read port, so whole-row work
// goes one cell per cycle: a scroll sweeps one row (rows are rotated through a
// base pointer, only the new bottom row is zeroed), a clear sweeps every cell.
// After reset a zeroing pass over every cell runs with o_in_ready low.
// A finished result sits in an output register; if the receiver stalls, the
// next command is still taken but its result waits until that register frees.

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [tcw_pkg::C_OP_W-1:0]       i_operation,
    input  logic [tcw_pkg::C_BYTE_W-1:0]     i_char_code,
    input  logic [tcw_pkg::C_BYTE_W-1:0]     i_attribute,
    input  logic                             i_at_cursor,
    input  logic [tcw_pkg::C_COL_W-1:0]      i_column,
    input  logic [tcw_pkg::C_ROW_W-1:0]      i_row_index,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [tcw_pkg::C_COL_W-1:0]      o_cursor_column,
    output logic [tcw_pkg::C_ROW_W-1:0]      o_cursor_row,
    output logic                             o_position_error,
    output logic [tcw_pkg::C_BYTE_W-1:0]     o_cell_char,
    output logic [tcw_pkg::C_BYTE_W-1:0]     o_cell_attr,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tcw_pkg::C_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcw_pkg::C_BYTE_W-1:0]     i_cfg_data
);

    import tcw_pkg::*;

    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (2 ** CW);

    localparam logic [CW-1:0] LAST_COL = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]          r_state, n_state;
    t_op                 r_op;
    logic [C_BYTE_W-1:0] r_ch, r_attr;
    logic                r_at_cur;
    logic [C_COL_W-1:0]  r_col;
    logic [C_ROW_W-1:0]  r_row;
    logic [CW-1:0]       r_cur_col, n_cur_col;
    logic [RW-1:0]       r_cur_row, n_cur_row;
    logic [RW-1:0]       r_base, n_base;
    logic                r_err, n_err;
    logic [RW-1:0]       r_sw_row, n_sw_row;
    logic [CW-1:0]       r_sw_col, n_sw_col;
    logic                r_sw_all, n_sw_all;
    t_cell               r_sw_data, n_sw_data;
    logic [C_BYTE_W-1:0] r_default, r_error_attr;
    logic                r_out_valid;
    logic [C_COL_W-1:0]  r_o_col;
    logic [C_ROW_W-1:0]  r_o_row;
    logic                r_o_err;
    t_cell               r_o_cell;

    // exec stage decode
    logic                off_screen;
    logic [CW-1:0]       pos_col, tgt_col;
    logic [RW-1:0]       pos_row, tgt_row;
    logic [C_BYTE_W-1:0] attr_eff;
    logic                ex_we, ex_re, scroll;
    t_cell               ex_wdata;
    logic [RW:0]         phys_sum;
    logic [RW-1:0]       phys_row;
    logic                sweep_end, out_load;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    t_cell               ram_wdata, ram_rdata;

    assign off_screen = !r_at_cur &&
                        (({1'b0, r_col} >= 8'(COLUMNS)) || ({1'b0, r_row} >= 6'(ROWS)));
    assign pos_col  = r_at_cur ? r_cur_col : r_col[CW-1:0];
    assign pos_row  = r_at_cur ? r_cur_row : r_row[RW-1:0];
    assign attr_eff = (r_attr == '0) ? r_default : r_attr;

    always_comb begin
        tgt_col   = pos_col;
        tgt_row   = pos_row;
        ex_we     = 1'b0;
        ex_re     = 1'b0;
        ex_wdata  = '{attr: attr_eff, ch: r_ch};
        scroll    = 1'b0;
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_err     = 1'b0;
        unique case (r_op)
            OP_PUT: begin
                if (off_screen) begin
                    tgt_col  = LAST_COL;
                    tgt_row  = LAST_ROW;
                    ex_we    = 1'b1;
                    ex_wdata = '{attr: r_error_attr, ch: CH_ERROR};
                    n_err    = 1'b1;
                end else if (r_ch == CH_BLANK) begin
                    ex_we     = 1'b1;
                    ex_wdata  = '{attr: attr_eff, ch: CH_SPACE};
                    n_cur_col = pos_col;
                    n_cur_row = pos_row;
                end else begin
                    ex_we = (r_ch != CH_NEWLINE);
                    if (r_ch == CH_NEWLINE || pos_col == LAST_COL) begin
                        n_cur_col = '0;
                        if (pos_row == LAST_ROW) begin
                            scroll    = 1'b1;
                            n_cur_row = pos_row;
                        end else begin
                            n_cur_row = pos_row + RW'(1);
                        end
                    end else begin
                        n_cur_col = pos_col + CW'(1);
                        n_cur_row = pos_row;
                    end
                end
            end
            OP_BKSP: begin
                if (r_cur_col != '0) begin
                    n_cur_col = r_cur_col - CW'(1);
                end else if (r_cur_row != '0) begin
                    n_cur_col = LAST_COL;
                    n_cur_row = r_cur_row - RW'(1);
                end
                tgt_col  = n_cur_col;
                tgt_row  = n_cur_row;
                ex_we    = 1'b1;
                ex_wdata = '{attr: r_default, ch: CH_SPACE};
            end
            OP_CLEAR: begin
                n_cur_col = '0;
                n_cur_row = '0;
            end
            OP_READ: begin
                n_err = off_screen;
                ex_re = !off_screen;
            end
            default: ;
        endcase
    end

    // logical row to memory row through the scroll base
    assign phys_sum = {1'b0, tgt_row} + {1'b0, r_base};
    assign phys_row = (phys_sum >= (RW+1)'(ROWS)) ? RW'(phys_sum - (RW+1)'(ROWS))
                                                  : phys_sum[RW-1:0];

    assign sweep_end = (r_sw_col == LAST_COL) && (!r_sw_all || r_sw_row == LAST_ROW);
    assign out_load  = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state   = r_state;
        n_base    = r_base;
        n_sw_row  = r_sw_row;
        n_sw_col  = r_sw_col;
        n_sw_all  = r_sw_all;
        n_sw_data = r_sw_data;
        unique case (r_state)
            ST_INIT, ST_SWEEP: begin
                if (r_sw_col == LAST_COL) begin
                    n_sw_col = '0;
                    n_sw_row = r_sw_row + RW'(1);
                end else begin
                    n_sw_col = r_sw_col + CW'(1);
                end
                if (sweep_end) begin
                    n_state = (r_state == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_sw_col = '0;
                if (r_op == OP_CLEAR) begin
                    n_base    = '0;
                    n_sw_row  = '0;
                    n_sw_all  = 1'b1;
                    n_sw_data = '{attr: r_default, ch: CH_SPACE};
                    n_state   = ST_SWEEP;
                end else if (scroll) begin
                    // old top row becomes the new bottom row
                    n_base    = (r_base == LAST_ROW) ? '0 : r_base + RW'(1);
                    n_sw_row  = r_base;
                    n_sw_all  = 1'b0;
                    n_sw_data = '0;
                    n_state   = ST_SWEEP;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_cur_col    <= '0;
            r_cur_row    <= '0;
            r_base       <= '0;
            r_sw_row     <= '0;
            r_sw_col     <= '0;
            r_sw_all     <= 1'b1;
            r_sw_data    <= '0;
            r_default    <= DEFAULT_ATTR_RST;
            r_error_attr <= ERROR_ATTR_RST;
            r_out_valid  <= 1'b0;
            r_err        <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_base    <= n_base;
            r_sw_row  <= n_sw_row;
            r_sw_col  <= n_sw_col;
            r_sw_all  <= n_sw_all;
            r_sw_data <= n_sw_data;
            if (r_state == ST_EXEC) begin
                r_cur_col <= n_cur_col;
                r_cur_row <= n_cur_row;
                r_err     <= n_err;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_DEFAULT_ATTR: r_default    <= i_cfg_data;
                    REG_ERROR_ATTR:   r_error_attr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in_valid) begin
            r_op     <= i_operation;
            r_ch     <= i_char_code;
            r_attr   <= i_attribute;
            r_at_cur <= i_at_cursor;
            r_col    <= i_column;
            r_row    <= i_row_index;
        end
        if (out_load) begin
            r_o_col  <= C_COL_W'(r_cur_col);
            r_o_row  <= C_ROW_W'(r_cur_row);
            r_o_err  <= r_err;
            r_o_cell <= (r_op == OP_READ && !r_err) ? ram_rdata : '0;
        end
    end

    always_comb begin
        if (r_state == ST_INIT || r_state == ST_SWEEP) begin
            ram_we    = 1'b1;
            ram_waddr = {r_sw_row, r_sw_col};
            ram_wdata = r_sw_data;
        end else begin
            ram_we    = (r_state == ST_EXEC) && ex_we;
            ram_waddr = {phys_row, tgt_col};
            ram_wdata = ex_wdata;
        end
    end
    assign ram_raddr = {phys_row, tgt_col};

    tcw_ram #(
        .WIDTH (C_CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    ((r_state == ST_EXEC) && ex_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready       = (r_state == ST_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_cursor_column  = r_o_col;
    assign o_cursor_row     = r_o_row;
    assign o_position_error = r_o_err;
    assign o_cell_char      = r_o_cell.ch;
    assign o_cell_attr      = r_o_cell.attr;

endmodule

// ----- rtl/tcw_ram.sv -----
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tcw_checker.sv -----
`timescale 1ns / 1ps

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [tcw_pkg::C_COL_W-1:0]  o_cursor_column,
    input logic [tcw_pkg::C_ROW_W-1:0]  o_cursor_row,
    input logic                         o_position_error,
    input logic [tcw_pkg::C_BYTE_W-1:0] o_cell_char,
    input logic [tcw_pkg::C_BYTE_W-1:0] o_cell_attr
);

    import tcw_pkg::*;

    // reported cursor always lies on the screen
    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_cursor_column} < 8'(COLUMNS)) &&
                        ({1'b0, o_cursor_row} < 6'(ROWS)))
        else $error("cursor off screen");

    // an off-screen request never returns cell contents
    a_err_no_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_position_error) |-> (o_cell_char == '0) && (o_cell_attr == '0))
        else $error("cell data with position error");

    // one command at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_cursor_column) &&
            $stable(o_cursor_row) && $stable(o_cell_char) && $stable(o_cell_attr))
        else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_cursor_column  (o_cursor_column),
    .o_cursor_row     (o_cursor_row),
    .o_position_error (o_position_error),
    .o_cell_char      (o_cell_char),
    .o_cell_attr      (o_cell_attr)
);

// ----- tb/text_console_writer_checker.sv -----
`timescale 1ns / 1ps

module text_console_writer_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [tcw_pkg::C_OP_W-1:0]       i_operation,
    input  logic [tcw_pkg::C_BYTE_W-1:0]     i_char_code,
    input  logic [tcw_pkg::C_BYTE_W-1:0]     i_attribute,
    input  logic                             i_at_cursor,
    input  logic [tcw_pkg::C_COL_W-1:0]      i_column,
    input  logic [tcw_pkg::C_ROW_W-1:0]      i_row_index,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [tcw_pkg::C_COL_W-1:0]      i_cursor_column,
    input  logic [tcw_pkg::C_ROW_W-1:0]      i_cursor_row,
    input  logic                             i_position_error,
    input  logic [tcw_pkg::C_BYTE_W-1:0]     i_cell_char,
    input  logic [tcw_pkg::C_BYTE_W-1:0]     i_cell_attr,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [tcw_pkg::C_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcw_pkg::C_BYTE_W-1:0]     i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;

    typedef struct packed {
        logic [C_COL_W-1:0]  col;
        logic [C_ROW_W-1:0]  row;
        logic                err;
        logic [C_BYTE_W-1:0] ch;
        logic [C_BYTE_W-1:0] attr;
    } t_console_reply;

    t_cell               screen [CELLS];
    int                  cursor_pos;
    logic [C_BYTE_W-1:0] default_attr;
    logic [C_BYTE_W-1:0] error_attr;
    t_console_reply      reply_queue [$];
    int                  fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic t_cell cell_of(logic [C_BYTE_W-1:0] ch, logic [C_BYTE_W-1:0] attr);
        t_cell c;
        c.ch   = ch;
        c.attr = attr;
        return c;
    endfunction

    // applies one command to the shadow screen and returns the reply it causes
    function automatic t_console_reply console_apply(t_op op, logic [C_BYTE_W-1:0] ch,
                                                     logic [C_BYTE_W-1:0] attr, logic at_cur,
                                                     logic [C_COL_W-1:0] col,
                                                     logic [C_ROW_W-1:0] row);
        t_console_reply r;
        logic           off;
        int             pos;
        int             next_pos;
        r   = '0;
        off = !at_cur && (int'(col) >= COLUMNS || int'(row) >= ROWS);
        pos = cursor_pos;
        if (!at_cur && !off)
            pos = int'(row) * COLUMNS + int'(col);
        if (pos >= CELLS)
            pos = 0;
        case (op)
            OP_PUT: begin
                if (off) begin
                    screen[CELLS-1] = cell_of(CH_ERROR, error_attr);
                    r.err = 1'b1;
                end else begin
                    if (attr == '0)
                        attr = default_attr;
                    if (ch == CH_NEWLINE) begin
                        next_pos = (pos / COLUMNS + 1) * COLUMNS;
                    end else if (ch == CH_BLANK) begin
                        screen[pos] = cell_of(CH_SPACE, attr);
                        next_pos = pos;
                    end else begin
                        screen[pos] = cell_of(ch, attr);
                        next_pos = pos + 1;
                    end
                    // past the last cell: scroll up, bottom row zeroed
                    if (next_pos >= CELLS) begin
                        for (int i = 0; i < CELLS - COLUMNS; i++)
                            screen[i] = screen[i + COLUMNS];
                        for (int i = CELLS - COLUMNS; i < CELLS; i++)
                            screen[i] = '0;
                        next_pos -= COLUMNS;
                    end
                    cursor_pos = next_pos;
                end
            end
            OP_BKSP: begin
                next_pos = (cursor_pos >= CELLS) ? 0 : cursor_pos;
                if (next_pos > 0)
                    next_pos--;
                screen[next_pos] = cell_of(CH_SPACE, default_attr);
                cursor_pos = next_pos;
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELLS; i++)
                    screen[i] = cell_of(CH_SPACE, default_attr);
                cursor_pos = 0;
            end
            default: begin
                if (off) begin
                    r.err = 1'b1;
                end else begin
                    r.ch   = screen[pos].ch;
                    r.attr = screen[pos].attr;
                end
            end
        endcase
        r.col = C_COL_W'(cursor_pos % COLUMNS);
        r.row = C_ROW_W'(cursor_pos / COLUMNS);
        return r;
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        if (fail_count < 40)
            $display("%0t: mismatch on %s, got %0d, expected %0d", $time, field, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_console_reply got;
        t_console_reply want;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++)
                screen[i] = '0;
            cursor_pos   = 0;
            default_attr = DEFAULT_ATTR_RST;
            error_attr   = ERROR_ATTR_RST;
            reply_queue.delete();
            o_pending    = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_DEFAULT_ATTR)
                    default_attr = i_cfg_data;
                else if (i_cfg_index == REG_ERROR_ATTR)
                    error_attr = i_cfg_data;
            end
            // a result transfer always belongs to an earlier command transfer
            if (i_out_valid && i_out_ready) begin
                got = '{i_cursor_column, i_cursor_row, i_position_error, i_cell_char,
                        i_cell_attr};
                if (reply_queue.size() == 0) begin
                    report_mismatch("result with none pending", 1, 0);
                end else begin
                    want = reply_queue.pop_front();
                    if (got.col !== want.col)
                        report_mismatch("cursor_column", got.col, want.col);
                    if (got.row !== want.row)
                        report_mismatch("cursor_row", got.row, want.row);
                    if (got.err !== want.err)
                        report_mismatch("position_error", got.err, want.err);
                    if (got.ch !== want.ch)
                        report_mismatch("cell_char", got.ch, want.ch);
                    if (got.attr !== want.attr)
                        report_mismatch("cell_attr", got.attr, want.attr);
                end
            end
            if (i_in_valid && i_in_ready)
                reply_queue.push_back(console_apply(i_operation, i_char_code, i_attribute,
                                                    i_at_cursor, i_column, i_row_index));
            o_pending = reply_queue.size();
        end
    end

endmodule

// ----- tb/text_console_writer_tb.sv -----
`timescale 1ns / 1ps

module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 255;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   in_valid    = 1'b0;
    logic                   in_ready;
    t_op                    operation   = OP_READ;
    logic [C_BYTE_W-1:0]    char_code   = '0;
    logic [C_BYTE_W-1:0]    attribute   = '0;
    logic                   at_cursor   = 1'b1;
    logic [C_COL_W-1:0]     column      = '0;
    logic [C_ROW_W-1:0]     row_index   = '0;
    logic                   out_valid;
    logic                   out_ready   = 1'b0;
    logic [C_COL_W-1:0]     cursor_column;
    logic [C_ROW_W-1:0]     cursor_row;
    logic                   position_error;
    logic [C_BYTE_W-1:0]    cell_char;
    logic [C_BYTE_W-1:0]    cell_attr;
    logic                   cfg_valid   = 1'b0;
    logic                   cfg_ready;
    logic [C_CFG_IDX_W-1:0] cfg_index   = REG_DEFAULT_ATTR;
    logic [C_BYTE_W-1:0]    cfg_data    = '0;
    int                     fail_count;
    int                     pending_count;

    bit idle_on      = 1'b1;
    bit hold_request = 1'b0;

    text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_operation      (operation),
        .i_char_code      (char_code),
        .i_attribute      (attribute),
        .i_at_cursor      (at_cursor),
        .i_column         (column),
        .i_row_index      (row_index),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_cursor_column  (cursor_column),
        .o_cursor_row     (cursor_row),
        .o_position_error (position_error),
        .o_cell_char      (cell_char),
        .o_cell_attr      (cell_attr),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    text_console_writer_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_operation      (operation),
        .i_char_code      (char_code),
        .i_attribute      (attribute),
        .i_at_cursor      (at_cursor),
        .i_column         (column),
        .i_row_index      (row_index),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_cursor_column  (cursor_column),
        .i_cursor_row     (cursor_row),
        .i_position_error (position_error),
        .i_cell_char      (cell_char),
        .i_cell_attr      (cell_attr),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending_count)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    initial begin
        #30_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        @(posedge clk iff rst_n);
        forever begin
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_request = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // valid stays up across back-to-back commands; only a gap or a drain lowers it
    task automatic send_cmd(t_op op, logic [C_BYTE_W-1:0] ch, logic [C_BYTE_W-1:0] attr,
                            logic at_cur, logic [C_COL_W-1:0] col, logic [C_ROW_W-1:0] row);
        in_valid  <= 1'b1;
        operation <= op;
        char_code <= ch;
        attribute <= attr;
        at_cursor <= at_cur;
        column    <= col;
        row_index <= row;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // stop sending until every pending result is back and the block has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic set_attrs(logic [C_BYTE_W-1:0] dflt, logic [C_BYTE_W-1:0] errv);
        cfg_valid <= 1'b1;
        cfg_index <= REG_DEFAULT_ATTR;
        cfg_data  <= dflt;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= REG_ERROR_ATTR;
        cfg_data  <= errv;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_cmd();
        t_op                 op;
        logic [C_BYTE_W-1:0] ch;
        logic [C_BYTE_W-1:0] attr;
        logic                at_cur;
        logic [C_COL_W-1:0]  col;
        logic [C_ROW_W-1:0]  row;
        int                  pick;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            op = OP_CLEAR;
        else if (pick < 12)
            op = OP_BKSP;
        else if (pick < 40)
            op = OP_READ;
        else
            op = OP_PUT;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            ch = CH_NEWLINE;
        else if (pick == 1)
            ch = CH_BLANK;
        else
            ch = C_BYTE_W'($urandom);
        attr   = ($urandom_range(0, 5) == 0) ? '0 : C_BYTE_W'($urandom);
        at_cur = ($urandom_range(0, 9) < 6);
        pick   = $urandom_range(0, 9);
        col    = (pick == 0) ? C_COL_W'($urandom_range(COLUMNS, 127))
                             : C_COL_W'($urandom_range(0, COLUMNS - 1));
        if (pick == 1)
            row = C_ROW_W'($urandom_range(ROWS, 31));
        else if (pick == 2)
            row = C_ROW_W'(ROWS - 1);
        else
            row = C_ROW_W'($urandom_range(0, ROWS - 1));
        if (pick == 3) begin
            col = C_COL_W'(COLUMNS - 1);
            row = C_ROW_W'(ROWS - 1);
        end
        send_cmd(op, ch, attr, at_cur, col, row);
    endtask

    // a line of typed text at the cursor, so wraps and scrolls get exercised
    task automatic send_text_run(output int count);
        logic [C_BYTE_W-1:0] ch;
        count = $urandom_range(8, 90);
        for (int i = 0; i < count; i++) begin
            ch = ($urandom_range(0, 15) == 0) ? CH_NEWLINE
                                               : C_BYTE_W'($urandom_range(8'h21, 8'h7E));
            send_cmd(OP_PUT, ch, ($urandom_range(0, 3) == 0) ? '0 : C_BYTE_W'($urandom),
                     1'b1, C_COL_W'($urandom), C_ROW_W'($urandom));
            if ($urandom_range(0, 7) == 0)
                sender_gap();
        end
    endtask

    initial begin
        int run_len;
        int sent;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset attributes in force
        send_cmd(OP_READ,  8'h00,      8'h00, 1'b1, 7'd0,   5'd0);
        send_cmd(OP_PUT,   8'h41,      8'h00, 1'b1, 7'd0,   5'd0);
        send_cmd(OP_PUT,   8'hFF,      8'hFF, 1'b0, 7'd0,   5'd0);
        send_cmd(OP_PUT,   8'h7A,      8'h12, 1'b0, 7'd79,  5'd24);
        send_cmd(OP_PUT,   CH_NEWLINE, 8'h00, 1'b1, 7'd0,   5'd0);
        send_cmd(OP_PUT,   CH_BLANK,   8'h31, 1'b0, 7'd5,   5'd3);
        send_cmd(OP_PUT,   8'h55,      8'h22, 1'b0, 7'd80,  5'd0);
        send_cmd(OP_PUT,   8'h55,      8'h22, 1'b0, 7'd127, 5'd31);
        send_cmd(OP_PUT,   8'h55,      8'h22, 1'b0, 7'd0,   5'd25);
        send_cmd(OP_READ,  8'h00,      8'h00, 1'b0, 7'd79,  5'd24);
        send_cmd(OP_READ,  8'h00,      8'h00, 1'b0, 7'd100, 5'd2);
        send_cmd(OP_BKSP,  8'h00,      8'h00, 1'b1, 7'd0,   5'd0);
        send_cmd(OP_READ,  8'h00,      8'h00, 1'b0, 7'd4,   5'd3);
        send_cmd(OP_PUT,   8'h00,      8'h80, 1'b0, 7'd0,   5'd0);
        send_cmd(OP_BKSP,  8'h00,      8'h00, 1'b1, 7'd0,   5'd0);
        send_cmd(OP_BKSP,  8'h00,      8'h00, 1'b1, 7'd0,   5'd0);
        send_cmd(OP_PUT,   CH_NEWLINE, 8'h00, 1'b0, 7'd40,  5'd10);
        send_cmd(OP_READ,  8'h00,      8'h00, 1'b1, 7'd0,   5'd0);
        send_cmd(OP_CLEAR, 8'h00,      8'h00, 1'b1, 7'd0,   5'd0);
        send_cmd(OP_READ,  8'h00,      8'h00, 1'b0, 7'd79,  5'd24);
        send_cmd(OP_PUT,   CH_NEWLINE, 8'h00, 1'b0, 7'd79,  5'd24);
        send_cmd(OP_PUT,   CH_BLANK,   8'h00, 1'b1, 7'd0,   5'd0);
        send_cmd(OP_READ,  8'h00,      8'h00, 1'b0, 7'd0,   5'd24);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0:       set_attrs(8'h00, 8'h00);
                1:       set_attrs(8'hFF, 8'hFF);
                3:       set_attrs(8'hFF, 8'h00);
                4:       set_attrs(8'h00, 8'hFF);
                default: set_attrs(C_BYTE_W'($urandom), C_BYTE_W'($urandom));
            endcase
            // closing phase runs with no idling on either side
            if (phase == PHASES - 1)
                idle_on = 1'b0;
            sent = 0;
            if (phase == 1) begin
                hold_request = 1'b1;
                repeat (40) send_random_cmd();
                sent = 40;
            end
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_text_run(run_len);
                    sent += run_len;
                end else begin
                    send_random_cmd();
                    sent++;
                end
                sender_gap();
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
